### src/gpiopi_pkg.sv
// gpiopi_pkg: shared constants, register offsets and the command type
// passed from the decode front end through the queue to the execute stage.
// No dependencies.
`default_nettype none

package gpiopi_pkg;

  localparam int PIN_COUNT_DEF = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // bus operations
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_DRIVE   = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // register offsets; 0x8C, 0xA0, 0xA4 and all others decode as bad
  localparam logic [7:0] OFS_CFG_LAST = 8'h7C;
  localparam logic [7:0] OFS_INTR     = 8'h80;
  localparam logic [7:0] OFS_GPIN     = 8'h84;
  localparam logic [7:0] OFS_GPOUT    = 8'h88;

  // per-pin config word fields
  localparam int CFG_OUT_EN_BIT = 0;
  localparam int CFG_IN_EN_BIT  = 1;
  localparam int CFG_INT_EN_BIT = 3;
  localparam int CFG_TYPE_LSB   = 5;
  localparam int CFG_TYPE_W     = 3;

  // interrupt type codes
  localparam logic [2:0] IRQ_HIGH = 3'd0;
  localparam logic [2:0] IRQ_LOW  = 3'd1;
  localparam logic [2:0] IRQ_RISE = 3'd2;
  localparam logic [2:0] IRQ_FALL = 3'd3;
  localparam logic [2:0] IRQ_EDGE = 3'd4;

  // command kinds produced by the decoder
  localparam logic [3:0] K_NOP         = 4'd0;
  localparam logic [3:0] K_RD_CFG      = 4'd1;
  localparam logic [3:0] K_RD_INTR     = 4'd2;
  localparam logic [3:0] K_RD_GPIN     = 4'd3;
  localparam logic [3:0] K_RD_GPOUT    = 4'd4;
  localparam logic [3:0] K_WR_CFG      = 4'd5;
  localparam logic [3:0] K_WR_INTR     = 4'd6;
  localparam logic [3:0] K_WR_RESOLVE  = 4'd7;
  localparam logic [3:0] K_WR_GPOUT    = 4'd8;
  localparam logic [3:0] K_PIN_DRIVE   = 4'd9;
  localparam logic [3:0] K_PIN_RELEASE = 4'd10;

  typedef struct packed {
    logic [3:0]  kind;
    logic        bad;
    logic        level;
    logic [4:0]  slot;
    logic [4:0]  pin;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### src/gpio_port_with_pin_interrupts.sv
// gpio_port_with_pin_interrupts: top level of the GPIO port with pin interrupts.
// Depends on gpiopi_pkg, gpiopi_front, gpiopi_queue and gpiopi_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  op, address, write_data, pin_index
//   out_     output     out_valid/out_stall  read_data, bad_access, irq, pin_levels
//
// One request per cycle sustained while results are not stalled; each request yields exactly one result.
// A result passes through the queue entry, written when its request is accepted,
// and then the result register, written when the execute stage pops the entry.
// Reset clears all port state, the queue and the result valid.
// A stalled result holds; the two-entry queue absorbs requests until full.
`default_nettype none

module gpio_port_with_pin_interrupts #(
  parameter int PIN_COUNT = gpiopi_pkg::PIN_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_address,
  input  wire logic [31:0] in_write_data,
  input  wire logic [4:0]  in_pin_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_bad_access,
  output logic             out_irq,
  output logic [31:0]      out_pin_levels
);
  import gpiopi_pkg::*;

  cmd_t    dec_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  gpiopi_front #(
    .PIN_COUNT (PIN_COUNT)
  ) u_front (
    .in_op         (in_op),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pin_index  (in_pin_index),
    .cmd           (dec_cmd)
  );

  gpiopi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (dec_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  gpiopi_back #(
    .PIN_COUNT (PIN_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head_cmd),
    .cmd_valid      (!q_stat.empty),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_bad_access (out_bad_access),
    .out_irq        (out_irq),
    .out_pin_levels (out_pin_levels)
  );

  // request into an empty pipe is presented after the queue entry and the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && q_stat.empty && !out_valid) |=> ##1 out_valid)
    else $error("request into empty pipe did not produce a result");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_access) |-> (out_read_data == '0))
    else $error("bad access returned nonzero read data");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("pipe not empty after reset");

endmodule

`default_nettype wire

### src/gpiopi_front.sv
// gpiopi_front: decodes one request (bus access or pin event) into a command.
// Depends on gpiopi_pkg.
`default_nettype none

module gpiopi_front #(
  parameter int PIN_COUNT = gpiopi_pkg::PIN_COUNT_DEF
) (
  input  wire logic [1:0]       in_op,
  input  wire logic [7:0]       in_address,
  input  wire logic [31:0]      in_write_data,
  input  wire logic [4:0]       in_pin_index,
  output gpiopi_pkg::cmd_t      cmd
);
  import gpiopi_pkg::*;

  logic cfg_hit;
  logic pin_ok;

  assign cfg_hit = (in_address <= OFS_CFG_LAST) && (in_address[1:0] == 2'b00) &&
                   ({2'b00, in_address[7:2]} < 8'(PIN_COUNT));
  assign pin_ok  = ({1'b0, in_pin_index} < 6'(PIN_COUNT));

  always_comb begin
    cmd       = '0;
    cmd.slot  = in_address[6:2];
    cmd.pin   = in_pin_index;
    cmd.data  = in_write_data;
    cmd.level = |in_write_data;
    unique case (in_op)
      OP_READ: begin
        priority if (cfg_hit)                cmd.kind = K_RD_CFG;
        else if (in_address == OFS_INTR)     cmd.kind = K_RD_INTR;
        else if (in_address == OFS_GPIN)     cmd.kind = K_RD_GPIN;
        else if (in_address == OFS_GPOUT)    cmd.kind = K_RD_GPOUT;
        else begin
          cmd.kind = K_NOP;
          cmd.bad  = 1'b1;
        end
      end
      OP_WRITE: begin
        priority if (cfg_hit)                cmd.kind = K_WR_CFG;
        else if (in_address == OFS_INTR)     cmd.kind = K_WR_INTR;
        else if (in_address == OFS_GPIN)     cmd.kind = K_WR_RESOLVE;
        else if (in_address == OFS_GPOUT)    cmd.kind = K_WR_GPOUT;
        else begin
          // bad write still resamples the pins
          cmd.kind = K_WR_RESOLVE;
          cmd.bad  = 1'b1;
        end
      end
      OP_DRIVE:   cmd.kind = pin_ok ? K_PIN_DRIVE : K_NOP;
      OP_RELEASE: cmd.kind = pin_ok ? K_PIN_RELEASE : K_NOP;
      default:    cmd.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

### src/gpiopi_queue.sv
// gpiopi_queue: short command queue between the decoder and the execute stage.
// Depends on gpiopi_pkg.
`default_nettype none

module gpiopi_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  gpiopi_pkg::cmd_t        push_cmd,
  input  wire logic               pop,
  output gpiopi_pkg::cmd_t        head_cmd,
  output gpiopi_pkg::q_stat_t     stat
);
  import gpiopi_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_cmd;
  end

  assign head_cmd   = entry_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

### src/gpiopi_back.sv
// gpiopi_back: executes commands against the port state, resolves and samples
// the pins, tracks pending conditions and holds the result register.
// Depends on gpiopi_pkg.
`default_nettype none

module gpiopi_back #(
  parameter int PIN_COUNT = gpiopi_pkg::PIN_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gpiopi_pkg::cmd_t   cmd,
  input  wire logic          cmd_valid,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        out_read_data,
  output logic               out_bad_access,
  output logic               out_irq,
  output logic [31:0]        out_pin_levels
);
  import gpiopi_pkg::*;

  localparam int SLOT_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  logic [31:0]          cfg_r [PIN_COUNT];
  logic [31:0]          cfg_nxt [PIN_COUNT];
  logic [PIN_COUNT-1:0] gpout_r, gpout_nxt;
  logic [PIN_COUNT-1:0] sample_r, sample_nxt;
  logic [PIN_COUNT-1:0] drv_r, drv_nxt;
  logic [PIN_COUNT-1:0] lvl_r, lvl_nxt;
  logic [PIN_COUNT-1:0] hi_r, hi_nxt;
  logic [PIN_COUNT-1:0] lo_r, lo_nxt;
  logic [PIN_COUNT-1:0] ri_r, ri_nxt;
  logic [PIN_COUNT-1:0] fa_r, fa_nxt;

  logic                 out_valid_r;
  logic [31:0]          read_data_r;
  logic                 bad_r;
  logic                 irq_r;
  logic [31:0]          levels_r;

  logic [PIN_COUNT-1:0] pin_bit;
  logic [PIN_COUNT-1:0] oe, ie, levels, now, hit;
  logic [31:0]          rd;
  logic                 resolve;

  assign cmd_pop = cmd_valid && (!out_valid_r || !out_stall);

  always_comb begin
    cfg_nxt   = cfg_r;
    gpout_nxt = gpout_r;
    drv_nxt   = drv_r;
    lvl_nxt   = lvl_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    ri_nxt    = ri_r;
    fa_nxt    = fa_r;
    rd        = '0;
    resolve   = 1'b0;
    pin_bit   = '0;
    pin_bit[cmd.pin[SLOT_W-1:0]] = 1'b1;

    unique case (cmd.kind)
      K_RD_CFG:   rd = cfg_r[cmd.slot[SLOT_W-1:0]];
      K_RD_INTR:  rd = 32'(hi_r | lo_r | ri_r | fa_r);
      K_RD_GPIN:  rd = 32'(sample_r);
      K_RD_GPOUT: rd = 32'(gpout_r);
      K_WR_CFG: begin
        cfg_nxt[cmd.slot[SLOT_W-1:0]] = cmd.data;
        resolve = 1'b1;
      end
      K_WR_INTR: begin
        hi_nxt  = hi_r & ~cmd.data[PIN_COUNT-1:0];
        lo_nxt  = lo_r & ~cmd.data[PIN_COUNT-1:0];
        ri_nxt  = ri_r & ~cmd.data[PIN_COUNT-1:0];
        fa_nxt  = fa_r & ~cmd.data[PIN_COUNT-1:0];
        resolve = 1'b1;
      end
      K_WR_RESOLVE: resolve = 1'b1;
      K_WR_GPOUT: begin
        gpout_nxt = cmd.data[PIN_COUNT-1:0];
        resolve   = 1'b1;
      end
      K_PIN_DRIVE: begin
        drv_nxt = drv_r | pin_bit;
        lvl_nxt = cmd.level ? (lvl_r | pin_bit) : (lvl_r & ~pin_bit);
        resolve = 1'b1;
      end
      K_PIN_RELEASE: begin
        drv_nxt = drv_r & ~pin_bit;
        resolve = 1'b1;
      end
      default: ;
    endcase

    for (int i = 0; i < PIN_COUNT; i++) begin
      oe[i] = cfg_nxt[i][CFG_OUT_EN_BIT];
      ie[i] = cfg_nxt[i][CFG_IN_EN_BIT];
    end

    // external drive wins, then own output, else low
    levels     = (drv_nxt & lvl_nxt) | (~drv_nxt & oe & gpout_nxt);
    now        = levels & ie;
    sample_nxt = sample_r;
    if (resolve) begin
      hi_nxt     = hi_nxt | now;
      lo_nxt     = lo_nxt | ~now;
      ri_nxt     = ri_nxt | (now & ~sample_r);
      fa_nxt     = fa_nxt | (~now & sample_r);
      sample_nxt = now;
    end

    for (int i = 0; i < PIN_COUNT; i++) begin
      hit[i] = 1'b0;
      if (cfg_nxt[i][CFG_INT_EN_BIT]) begin
        unique case (cfg_nxt[i][CFG_TYPE_LSB +: CFG_TYPE_W])
          IRQ_HIGH: hit[i] = hi_nxt[i];
          IRQ_LOW:  hit[i] = lo_nxt[i];
          IRQ_RISE: hit[i] = ri_nxt[i];
          IRQ_FALL: hit[i] = fa_nxt[i];
          IRQ_EDGE: hit[i] = ri_nxt[i] | fa_nxt[i];
          default:  hit[i] = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIN_COUNT; i++) cfg_r[i] <= '0;
      gpout_r  <= '0;
      sample_r <= '0;
      drv_r    <= '0;
      lvl_r    <= '0;
      hi_r     <= '0;
      lo_r     <= '0;
      ri_r     <= '0;
      fa_r     <= '0;
    end else if (cmd_pop) begin
      cfg_r    <= cfg_nxt;
      gpout_r  <= gpout_nxt;
      sample_r <= sample_nxt;
      drv_r    <= drv_nxt;
      lvl_r    <= lvl_nxt;
      hi_r     <= hi_nxt;
      lo_r     <= lo_nxt;
      ri_r     <= ri_nxt;
      fa_r     <= fa_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      read_data_r <= rd;
      bad_r       <= cmd.bad;
      irq_r       <= |hit;
      levels_r    <= 32'(levels);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = read_data_r;
  assign out_bad_access = bad_r;
  assign out_irq        = irq_r;
  assign out_pin_levels = levels_r;

endmodule

`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for gpio_port_with_pin_interrupts, register map, pin events and irq.
// Needs gpiopi_pkg and the RTL under src; a built-in predictor or a scripted response checks every response in order.
`timescale 1ns / 100ps

module tb;
  import gpiopi_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [4:0]  pin_index;
  } request_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_access;
    logic        irq;
    logic [31:0] pin_levels;
  } response_t;

  typedef struct packed {
    request_t  req;
    logic      typed;
    response_t rsp;
  } script_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_MOSTLY, STALL_LONG} stall_mode_t;

  localparam logic [7:0]  OFS_BAD_8C    = 8'h8C;
  localparam logic [7:0]  OFS_BAD_A0    = 8'hA0;
  localparam logic [7:0]  OFS_BAD_A4    = 8'hA4;
  localparam logic [7:0]  OFS_UNALIGNED = 8'h01;
  localparam logic [7:0]  OFS_TOP       = 8'hFF;
  localparam logic [2:0]  IRQ_OFF       = 3'd7;
  localparam logic [31:0] CFG_OE        = 32'(1) << CFG_OUT_EN_BIT;
  localparam logic [31:0] CFG_IE        = 32'(1) << CFG_IN_EN_BIT;
  localparam logic [31:0] CFG_INTE      = 32'(1) << CFG_INT_EN_BIT;
  localparam logic [31:0] CFG_SENSE     = CFG_IE | CFG_INTE;
  localparam int          SCRIPT_LEN    = 25;
  localparam int          RANDOM_ITEMS  = 1600;

  localparam response_t IDLE_OK  = '{32'h0, 1'b0, 1'b0, 32'h0};
  localparam response_t IDLE_BAD = '{32'h0, 1'b1, 1'b0, 32'h0};
  localparam response_t UNTYPED  = '0;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // fresh out of reset, then every kind of bad offset
    '{'{OP_READ,  8'h00,         32'h0,          5'd0},  1'b1, IDLE_OK},
    '{'{OP_READ,  OFS_BAD_8C,    32'h0,          5'd0},  1'b1, IDLE_BAD},
    '{'{OP_WRITE, OFS_BAD_A0,    32'hFFFFFFFF,   5'd31}, 1'b1, IDLE_BAD},
    '{'{OP_READ,  OFS_BAD_A4,    32'h0,          5'd0},  1'b1, IDLE_BAD},
    '{'{OP_READ,  OFS_UNALIGNED, 32'h0,          5'd0},  1'b1, IDLE_BAD},
    '{'{OP_WRITE, OFS_TOP,       32'hFFFFFFFF,   5'd0},  1'b1, IDLE_BAD},
    '{'{OP_WRITE, OFS_GPIN,      32'hFFFFFFFF,   5'd0},  1'b0, UNTYPED},
    '{'{OP_WRITE, 8'h00, CFG_SENSE | CFG_OE | {IRQ_HIGH, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_WRITE, OFS_GPOUT,     32'hFFFFFFFF,   5'd0},  1'b0, UNTYPED},
    '{'{OP_READ,  OFS_INTR,      32'h0,          5'd0},  1'b0, UNTYPED},
    // clear all pending, condition still holds so bits come straight back
    '{'{OP_WRITE, OFS_INTR,      32'hFFFFFFFF,   5'd0},  1'b0, UNTYPED},
    '{'{OP_READ,  OFS_GPIN,      32'h0,          5'd0},  1'b0, UNTYPED},
    '{'{OP_WRITE, OFS_CFG_LAST, CFG_SENSE | {IRQ_RISE, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_DRIVE, 8'h00,         32'h00000001,   5'd31}, 1'b0, UNTYPED},
    '{'{OP_DRIVE, 8'h00,         32'h0,          5'd31}, 1'b0, UNTYPED},
    '{'{OP_WRITE, 8'(4 * 5), CFG_SENSE | {IRQ_FALL, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_DRIVE, 8'h00,         32'hFFFFFFFF,   5'd5},  1'b0, UNTYPED},
    '{'{OP_RELEASE, 8'h00,       32'h0,          5'd5},  1'b0, UNTYPED},
    '{'{OP_WRITE, 8'(4 * 7), CFG_SENSE | {IRQ_LOW, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_WRITE, 8'(4 * 9), CFG_SENSE | {IRQ_EDGE, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_WRITE, 8'(4 * 10), CFG_SENSE | CFG_OE | {IRQ_OFF, 5'b0}, 5'd0}, 1'b0, UNTYPED},
    '{'{OP_RELEASE, 8'h00,       32'h0,          5'd31}, 1'b0, UNTYPED},
    '{'{OP_WRITE, OFS_INTR,      32'hFFFFFFFF,   5'd0},  1'b0, UNTYPED},
    '{'{OP_READ,  OFS_GPOUT,     32'h0,          5'd0},  1'b0, UNTYPED},
    '{'{OP_WRITE, 8'h00,         32'hFFFFFFFF,   5'd0},  1'b0, UNTYPED}
  };

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_READ;
  logic [7:0]  in_address = '0;
  logic [31:0] in_write_data = '0;
  logic [4:0]  in_pin_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic        out_bad_access;
  logic        out_irq;
  logic [31:0] out_pin_levels;

  gpio_port_with_pin_interrupts uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_pin_index   (in_pin_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_bad_access (out_bad_access),
    .out_irq        (out_irq),
    .out_pin_levels (out_pin_levels)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predicted port state
  logic [31:0] pin_cfg [32];
  logic [31:0] gpin_sample, gpout_reg;
  logic [31:0] pend_high, pend_low, pend_rise, pend_fall;
  logic [31:0] ext_level, ext_driven;

  response_t   awaited_responses [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_tick = '0;

  function automatic logic [31:0] cfg_column(input int bit_pos);
    logic [31:0] col;
    col = '0;
    for (int p = 0; p < 32; p++) col[p] = pin_cfg[p][bit_pos];
    return col;
  endfunction

  function automatic logic [31:0] pin_levels_now();
    return (ext_driven & ext_level) | (~ext_driven & cfg_column(CFG_OUT_EN_BIT) & gpout_reg);
  endfunction

  function automatic void resample_pins();
    logic [31:0] now;
    now = pin_levels_now() & cfg_column(CFG_IN_EN_BIT);
    pend_high |= now;
    pend_low |= ~now;
    pend_rise |= now & ~gpin_sample;
    pend_fall |= ~now & gpin_sample;
    gpin_sample = now;
  endfunction

  function automatic logic irq_now();
    logic hit;
    hit = 1'b0;
    for (int p = 0; p < 32; p++) begin
      if (pin_cfg[p][CFG_INT_EN_BIT]) begin
        case (pin_cfg[p][CFG_TYPE_LSB +: CFG_TYPE_W])
          IRQ_HIGH: hit |= pend_high[p];
          IRQ_LOW:  hit |= pend_low[p];
          IRQ_RISE: hit |= pend_rise[p];
          IRQ_FALL: hit |= pend_fall[p];
          IRQ_EDGE: hit |= pend_rise[p] | pend_fall[p];
          default:  ;
        endcase
      end
    end
    return hit;
  endfunction

  function automatic response_t predict_access(input request_t req);
    response_t rsp;
    logic      is_cfg;
    rsp = '0;
    is_cfg = (req.address <= OFS_CFG_LAST) && (req.address[1:0] == 2'b00);
    case (req.op)
      OP_READ: begin
        if (is_cfg) rsp.read_data = pin_cfg[req.address[6:2]];
        else if (req.address == OFS_INTR)
          rsp.read_data = pend_high | pend_low | pend_rise | pend_fall;
        else if (req.address == OFS_GPIN) rsp.read_data = gpin_sample;
        else if (req.address == OFS_GPOUT) rsp.read_data = gpout_reg;
        else rsp.bad_access = 1'b1;
      end
      OP_WRITE: begin
        if (is_cfg) pin_cfg[req.address[6:2]] = req.write_data;
        else if (req.address == OFS_INTR) begin
          pend_high &= ~req.write_data;
          pend_low &= ~req.write_data;
          pend_rise &= ~req.write_data;
          pend_fall &= ~req.write_data;
        end else if (req.address == OFS_GPOUT) gpout_reg = req.write_data;
        else if (req.address != OFS_GPIN) rsp.bad_access = 1'b1;
        resample_pins();
      end
      OP_DRIVE: begin
        ext_driven[req.pin_index] = 1'b1;
        ext_level[req.pin_index] = |req.write_data;
        resample_pins();
      end
      default: begin
        ext_driven[req.pin_index] = 1'b0;
        resample_pins();
      end
    endcase
    rsp.irq = irq_now();
    rsp.pin_levels = pin_levels_now();
    return rsp;
  endfunction

  function automatic request_t random_request();
    request_t   req;
    logic [7:0] good_ofs;
    int         pick;
    req.write_data = $urandom;
    req.pin_index = 5'($urandom_range(0, 31));
    req.address = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: good_ofs = {1'b0, 5'($urandom_range(0, 31)), 2'b00};
      1: good_ofs = OFS_INTR;
      2: good_ofs = OFS_GPIN;
      default: good_ofs = OFS_GPOUT;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      req.op = OP_READ;
      if ($urandom_range(0, 9) < 7) req.address = good_ofs;
    end else if (pick < 60) begin
      req.op = OP_WRITE;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        // keep interrupt enables sparse so irq does not sit high forever
        req.address = {1'b0, 5'($urandom_range(0, 31)), 2'b00};
        req.write_data[CFG_IN_EN_BIT] = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 5) != 0) req.write_data[CFG_INT_EN_BIT] = 1'b0;
      end else if (pick < 15) begin
        req.address = OFS_INTR;
        if ($urandom_range(0, 1) == 0) req.write_data = '1;
      end else if (pick < 17) req.address = OFS_GPOUT;
      else if (pick < 18) req.address = OFS_GPIN;
    end else if (pick < 82) begin
      req.op = OP_DRIVE;
      if ($urandom_range(0, 1) == 0) req.write_data = '0;
    end else begin
      req.op = OP_RELEASE;
    end
    return req;
  endfunction

  task automatic issue(input request_t req, input logic typed, input response_t typed_rsp);
    response_t predicted;
    in_valid = 1'b1;
    in_op = req.op;
    in_address = req.address;
    in_write_data = req.write_data;
    in_pin_index = req.pin_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_access(req);
    awaited_responses.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
    // bursts of back-to-back requests separated by random gaps
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_MOSTLY: out_stall <= (stall_tick[1:0] != 2'd0);
      default:      out_stall <= stall_tick[3];
    endcase
  end

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_responses.size() == 0) begin
        $error("unexpected response: read_data %h bad_access %b", out_read_data,
               out_bad_access);
        mismatch_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_read_data);
          mismatch_count++;
        end
        if (out_bad_access !== want.bad_access) begin
          $error("bad_access: expected %b, got %b", want.bad_access, out_bad_access);
          mismatch_count++;
        end
        if (out_irq !== want.irq) begin
          $error("irq: expected %b, got %b", want.irq, out_irq);
          mismatch_count++;
        end
        if (out_pin_levels !== want.pin_levels) begin
          $error("pin_levels: expected %h, got %h", want.pin_levels, out_pin_levels);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(3_000_000);
    $display("gpio_port_with_pin_interrupts test failed");
    $finish;
  end

  initial begin
    for (int p = 0; p < 32; p++) pin_cfg[p] = '0;
    gpin_sample = '0;
    gpout_reg = '0;
    pend_high = '0;
    pend_low = '0;
    pend_rise = '0;
    pend_fall = '0;
    ext_level = '0;
    ext_driven = '0;
    // hold reset, then release at the falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int r = 0; r < SCRIPT_LEN; r++) issue(SCRIPT[r].req, SCRIPT[r].typed, SCRIPT[r].rsp);
    repeat (RANDOM_ITEMS) issue(random_request(), 1'b0, UNTYPED);
    in_valid = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("gpio_port_with_pin_interrupts test passed");
    else $display("gpio_port_with_pin_interrupts test failed");
    $finish;
  end

endmodule
